### hdl/sble_pkg.sv
// ----------------------------------------------------------------------------
// sble_pkg
// Shared constants and types for the sorted byte list engine.
// ----------------------------------------------------------------------------
package sble_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_ELEMENT   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_DEL_FIND,
        S_DEL_SHIFT,
        S_DUMP,
        S_REPLY
    } t_state;

    typedef enum logic [1:0] {
        OFF_HOLD,
        OFF_NEXT,
        OFF_PREV
    } t_rd_off;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC,
        IDX_LOAD_ZERO,
        IDX_LOAD_COUNT
    } t_idx_op;

    typedef enum logic [1:0] {
        ITEM_VALUE,
        ITEM_DATA,
        ITEM_ZERO
    } t_item_sel;

    typedef enum logic {
        WR_VALUE,
        WR_DATA
    } t_wr_sel;

    typedef struct packed {
        logic      load_value;
        logic      value_zero;
        t_idx_op   idx_op;
        t_rd_off   rd_off;
        logic      wr_en;
        t_wr_sel   wr_sel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      emit;
        t_status   emit_status;
        t_item_sel item_sel;
        logic      emit_last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic idx_zero;
        logic data_lt;
        logic data_eq;
        logic at_end;
        logic out_free;
    } t_stat;

endpackage

### hdl/sorted_byte_list_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_byte_list_engine_unit
// Ascending list of bytes, duplicates allowed, with insert, delete and dump.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one word: i_mode and i_value.
// Insert places the value ahead of the first entry not smaller; delete
// removes the first equal entry; dump streams every entry in order.
// Output channel (o_out_valid / i_out_stall) gives o_status, o_item, o_last;
// o_last marks the final word of each input word. Unused mode gives nothing.
// One input word is worked on at a time; o_in_stall is high while busy.
// Each word walks the store one entry per cycle through a single read
// port, a dump only while the output is not stalled: insert moves up
// each entry at or above the value, delete scans up to the match and
// moves the entries above it down, dump reads out every entry. A full
// insert, or a delete or dump on an empty list, gives one reply word.
// A result sits in an output register, so the next input word can be
// taken while it waits. Receiver stall holds the output word and pauses
// a dump in place. Synchronous reset empties the list; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_byte_list_engine_unit
    import sble_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_item,
    output logic       o_last
);

    t_cmd  cmd;
    t_stat stat;

    sble_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sble_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_item      (o_item),
        .o_last      (o_last)
    );

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result issued over an unaccepted word");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !cmd.wr_en)
        else $error("store written while idle");

    a_single_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_ELEMENT) |-> o_last)
        else $error("single result without last");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_inc |-> !stat.full)
        else $error("entry count overflow");

endmodule

### hdl/sble_datapath.sv
// ----------------------------------------------------------------------------
// sble_datapath
// Entry store, scan index, entry count and the output word register.
// ----------------------------------------------------------------------------
module sble_datapath
    import sble_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_value,
    input  logic       i_out_stall,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output logic [2:0] o_status,
    output logic [7:0] o_item,
    output logic       o_last
);

    logic [7:0]        r_mem [CAPACITY];
    logic [7:0]        r_rd_data;
    logic [7:0]        r_value;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  rd_full;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        wr_data;
    logic              r_out_valid;
    logic [2:0]        r_status;
    logic [7:0]        r_item;
    logic              r_last;
    logic              out_free;

    always_comb begin
        case (i_cmd.idx_op)
            IDX_HOLD:       n_idx = r_idx;
            IDX_INC:        n_idx = r_idx + CNT_W'(1);
            IDX_DEC:        n_idx = r_idx - CNT_W'(1);
            IDX_LOAD_ZERO:  n_idx = '0;
            IDX_LOAD_COUNT: n_idx = r_count;
            default:        n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_off)
            OFF_HOLD: rd_full = n_idx;
            OFF_NEXT: rd_full = n_idx + CNT_W'(1);
            OFF_PREV: rd_full = n_idx - CNT_W'(1);
            default:  rd_full = n_idx;
        endcase
    end

    assign rd_addr = rd_full[ADDR_W-1:0];
    assign wr_data = (i_cmd.wr_sel == WR_VALUE) ? r_value : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_idx[ADDR_W-1:0]] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_idx     <= n_idx;
        if (i_cmd.load_value) begin
            r_value <= i_cmd.value_zero ? 8'd0 : i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.emit_status;
            r_last   <= i_cmd.emit_last;
            case (i_cmd.item_sel)
                ITEM_VALUE: r_item <= r_value;
                ITEM_DATA:  r_item <= r_rd_data;
                ITEM_ZERO:  r_item <= 8'd0;
                default:    r_item <= r_value;
            endcase
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CNT_W'(CAPACITY));
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.data_lt  = (r_rd_data < r_value);
    assign o_stat.data_eq  = (r_rd_data == r_value);
    assign o_stat.at_end   = ((r_idx + CNT_W'(1)) == r_count);
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_item      = r_item;
    assign o_last      = r_last;

endmodule

### hdl/sble_control.sv
// ----------------------------------------------------------------------------
// sble_control
// Insert/delete/dump sequencer: one entry a cycle; output stall holds a dump.
// ----------------------------------------------------------------------------
module sble_control
    import sble_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  t_stat      i_stat,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    t_state  r_state;
    t_state  n_state;
    t_status r_reply;
    t_status n_reply;
    t_mode   mode;

    assign mode       = t_mode'(i_mode);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_reply <= ST_INSERTED;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (mode)
                        MODE_INSERT: begin
                            if (i_stat.full) begin
                                n_reply = ST_FULL;
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_INSERT;
                            end
                        end
                        MODE_DELETE: begin
                            if (i_stat.empty) begin
                                n_reply = ST_EMPTY;
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_DEL_FIND;
                            end
                        end
                        MODE_DUMP: begin
                            if (i_stat.empty) begin
                                n_reply = ST_EMPTY;
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INSERT: begin
                if (i_stat.idx_zero || i_stat.data_lt) begin
                    n_reply = ST_INSERTED;
                    n_state = S_REPLY;
                end
            end
            S_DEL_FIND: begin
                if (i_stat.data_eq) begin
                    n_state = S_DEL_SHIFT;
                end else if (!(i_stat.data_lt && !i_stat.at_end)) begin
                    n_reply = ST_NOT_FOUND;
                    n_state = S_REPLY;
                end
            end
            S_DEL_SHIFT: begin
                if (i_stat.at_end) begin
                    n_reply = ST_DELETED;
                    n_state = S_REPLY;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free && i_stat.at_end) begin
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.idx_op      = IDX_HOLD;
        o_cmd.rd_off      = OFF_HOLD;
        o_cmd.wr_sel      = WR_VALUE;
        o_cmd.emit_status = r_reply;
        o_cmd.item_sel    = ITEM_VALUE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (mode)
                        MODE_INSERT: begin
                            o_cmd.load_value = 1'b1;
                            o_cmd.idx_op     = IDX_LOAD_COUNT;
                            o_cmd.rd_off     = OFF_PREV;
                        end
                        MODE_DELETE: begin
                            o_cmd.load_value = 1'b1;
                            o_cmd.idx_op     = IDX_LOAD_ZERO;
                        end
                        MODE_DUMP: begin
                            o_cmd.load_value = 1'b1;
                            o_cmd.value_zero = 1'b1;
                            o_cmd.idx_op     = IDX_LOAD_ZERO;
                        end
                        default: o_cmd.load_value = 1'b0;
                    endcase
                end
            end
            S_INSERT: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.idx_zero || i_stat.data_lt) begin
                    o_cmd.wr_sel  = WR_VALUE;
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    o_cmd.wr_sel = WR_DATA;
                    o_cmd.idx_op = IDX_DEC;
                    o_cmd.rd_off = OFF_PREV;
                end
            end
            S_DEL_FIND: begin
                if (i_stat.data_eq) begin
                    o_cmd.rd_off = OFF_NEXT;
                end else if (i_stat.data_lt && !i_stat.at_end) begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_DEL_SHIFT: begin
                if (i_stat.at_end) begin
                    o_cmd.cnt_dec = 1'b1;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_DATA;
                    o_cmd.idx_op = IDX_INC;
                    o_cmd.rd_off = OFF_NEXT;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_ELEMENT;
                    o_cmd.item_sel    = ITEM_DATA;
                    o_cmd.emit_last   = i_stat.at_end;
                    o_cmd.idx_op      = IDX_INC;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                end
            end
            default: o_cmd.emit = 1'b0;
        endcase
    end

endmodule
